FILE: hdl/drmud_pkg.sv
// Shared types and constants for the damage rectangle merge / upload decision block.
// No dependencies; imported by drmud_clip and damage_rect_merge_upload_decide.
package drmud_pkg;

    localparam int COORD_W   = 16;   // input rectangle fields
    localparam int CFG_W     = 14;   // surface size registers
    localparam int OUT_DIM_W = 14;   // merged box fields
    localparam int AREA_W    = 42;
    localparam int CNT_W     = 16;
    localparam int MPIX_W    = 27;
    localparam int BYTES_W   = 29;
    localparam int IN_DATA_W = 64;
    localparam int OUT_DATA_W = 176;

    localparam logic [AREA_W-1:0] AREA_MAX  = {AREA_W{1'b1}};
    localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};

    // full upload when merged * PCT_ALL >= surface * PCT_FULL
    localparam int PCT_ALL       = 100;
    localparam int PCT_FULL      = 60;
    localparam int BYTES_PER_PIX = 4;

    // register indexes
    localparam logic REG_SURF_W = 1'b0;
    localparam logic REG_SURF_H = 1'b1;

    typedef logic signed [COORD_W-1:0] t_coord;

    // result word, lowest field last in this list (lowest bits)
    typedef struct packed {
        logic [3:0]           pad;
        logic [BYTES_W-1:0]   upload_bytes;
        logic                 partial_upload;
        logic                 full_upload;
        logic [MPIX_W-1:0]    merged_pixels;
        logic [CNT_W-1:0]     rect_count;
        logic [AREA_W-1:0]    damage_pixels;
        logic [OUT_DIM_W-1:0] merged_h;
        logic [OUT_DIM_W-1:0] merged_w;
        logic [OUT_DIM_W-1:0] merged_y;
        logic [OUT_DIM_W-1:0] merged_x;
    } t_result;

endpackage

FILE: hdl/drmud_clip.sv
// Clips one damage rectangle against the surface [0,W) x [0,H).
// Uses drmud_pkg.
module drmud_clip #(
    parameter int DW = 14
) (
    input  drmud_pkg::t_coord i_x,
    input  drmud_pkg::t_coord i_y,
    input  drmud_pkg::t_coord i_w,
    input  drmud_pkg::t_coord i_h,
    input  logic              i_valid,
    input  logic [DW-1:0]     i_sw,
    input  logic [DW-1:0]     i_sh,
    output logic [DW-1:0]     o_l,
    output logic [DW-1:0]     o_t,
    output logic [DW-1:0]     o_r,
    output logic [DW-1:0]     o_b,
    output logic              o_nonempty
);
    import drmud_pkg::*;

    localparam int EW = COORD_W + 2;

    logic signed [EW-1:0] x_end, y_end, sw_s, sh_s;
    logic signed [EW-1:0] left, top, right, bottom;

    assign x_end = EW'(i_x) + EW'(i_w);
    assign y_end = EW'(i_y) + EW'(i_h);
    assign sw_s  = $signed(EW'(i_sw));
    assign sh_s  = $signed(EW'(i_sh));

    assign left   = i_x[COORD_W-1] ? '0 : EW'(i_x);
    assign top    = i_y[COORD_W-1] ? '0 : EW'(i_y);
    assign right  = (x_end > sw_s) ? sw_s : x_end;
    assign bottom = (y_end > sh_s) ? sh_s : y_end;

    assign o_nonempty = i_valid
                        && !i_w[COORD_W-1] && (|i_w)
                        && !i_h[COORD_W-1] && (|i_h)
                        && (right > left) && (bottom > top);

    // when nonempty all edges lie within [0, surface size]
    assign o_l = left[DW-1:0];
    assign o_t = top[DW-1:0];
    assign o_r = right[DW-1:0];
    assign o_b = bottom[DW-1:0];

endmodule

FILE: hdl/drmud_mul.sv
// Shared unsigned multiplier with registered product.
// No dependencies.
module drmud_mul #(
    parameter int DW = 14
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [DW-1:0]   i_a,
    input  logic [DW-1:0]   i_b,
    output logic [2*DW-1:0] o_p
);
    localparam int PW = 2 * DW;

    logic [PW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= PW'(i_a) * PW'(i_b);
        end
    end

    assign o_p = r_p;

endmodule

FILE: hdl/damage_rect_merge_upload_decide.sv
// Damage rectangle merge and upload decision. Uses drmud_pkg, drmud_clip, drmud_mul.
// Schedule: one multiplier shared under a six-state sequencer. A rectangle that is not
// last passes through capture and the area multiply, then the block returns to idle and
// takes the next one. A last item goes on through S_LACC, S_MBOX, S_SURF and S_DEC: area,
// box area and surface area go through the multiplier in turn; the result is registered in S_DEC.
// Reset: synchronous, active low; surface size back to 1x1, accumulation cleared.
module damage_rect_merge_upload_decide #(
    parameter int MAX_DIM = 8192
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // rect_x, rect_y, rect_w, rect_h
    input  logic [drmud_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // rect_valid
    input  logic                                i_s_tuser,
    input  logic                                i_s_tlast,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // merged_x, merged_y, merged_w, merged_h, damage_pixels, rect_count,
    // merged_pixels, full_upload, partial_upload, upload_bytes, zero pad
    output logic [drmud_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_index,
    input  logic [drmud_pkg::CFG_W-1:0]         i_cfg_data
);
    import drmud_pkg::*;

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int PW = 2 * DW;
    localparam int CW = (DW > CFG_W) ? DW : CFG_W;
    localparam int KW = PW + 8;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_AREA = 3'd1;
    localparam logic [2:0] S_LACC = 3'd2;
    localparam logic [2:0] S_MBOX = 3'd3;
    localparam logic [2:0] S_SURF = 3'd4;
    localparam logic [2:0] S_DEC  = 3'd5;

    logic [2:0] r_state, n_state;

    logic [CFG_W-1:0] r_surf_w, r_surf_h;
    logic [DW-1:0]    sw, sh;
    logic [CW-1:0]    sw_ext, sh_ext;

    // captured clip result
    logic [DW-1:0] r_cl, r_ct, r_cr, r_cb;
    logic          r_c_ne, r_c_last, r_pend;
    logic [DW-1:0] cl, ct, cr, cb;
    logic          c_ne;

    // accumulation
    logic              r_have_box;
    logic [DW-1:0]     r_box_l, r_box_t, r_box_r, r_box_b;
    logic [AREA_W-1:0] r_area_sum;
    logic [CNT_W-1:0]  r_count;
    logic [PW-1:0]     r_mp;

    logic          acc_en, in_xfer, out_load;
    logic [AREA_W:0] sum_wide;
    logic [DW-1:0] mul_a, mul_b, box_w, box_h;
    logic          mul_en;
    logic [PW-1:0] prod, mp_sel, up_sel;
    logic [KW-1:0] lhs, rhs;
    logic          full;

    t_result r_out;
    logic    r_out_valid;

    // ---- configuration ----
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_surf_w <= CFG_W'(1);
            r_surf_h <= CFG_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SURF_W: r_surf_w <= i_cfg_data;
                REG_SURF_H: r_surf_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign sw_ext = CW'(r_surf_w);
    assign sh_ext = CW'(r_surf_h);
    assign sw = (sw_ext == '0) ? DW'(1) :
                (sw_ext > CW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(sw_ext);
    assign sh = (sh_ext == '0) ? DW'(1) :
                (sh_ext > CW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(sh_ext);

    // ---- clip ----
    drmud_clip #(.DW(DW)) u_clip (
        .i_x        (t_coord'(i_s_tdata[15:0])),
        .i_y        (t_coord'(i_s_tdata[31:16])),
        .i_w        (t_coord'(i_s_tdata[47:32])),
        .i_h        (t_coord'(i_s_tdata[63:48])),
        .i_valid    (i_s_tuser),
        .i_sw       (sw),
        .i_sh       (sh),
        .o_l        (cl),
        .o_t        (ct),
        .o_r        (cr),
        .o_b        (cb),
        .o_nonempty (c_ne)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign in_xfer    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cl <= cl;
            r_ct <= ct;
            r_cr <= cr;
            r_cb <= cb;
        end
    end

    // ---- shared multiplier ----
    assign box_w = r_box_r - r_box_l;
    assign box_h = r_box_b - r_box_t;

    always_comb begin
        mul_a  = sw;
        mul_b  = sh;
        mul_en = 1'b0;
        unique case (r_state)
            S_AREA: begin
                mul_a  = r_cr - r_cl;
                mul_b  = r_cb - r_ct;
                mul_en = 1'b1;
            end
            S_MBOX: begin
                mul_a  = box_w;
                mul_b  = box_h;
                mul_en = 1'b1;
            end
            S_SURF: begin
                mul_en = 1'b1;
            end
            default: ;
        endcase
    end

    drmud_mul #(.DW(DW)) u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // ---- decision (surface area sits in prod during S_DEC) ----
    assign mp_sel = r_have_box ? r_mp : prod;
    assign lhs    = KW'(mp_sel) * KW'(PCT_ALL);
    assign rhs    = KW'(prod) * KW'(PCT_FULL);
    assign full   = !r_have_box || (lhs >= rhs);
    assign up_sel = full ? prod : mp_sel;

    assign out_load = (r_state == S_DEC) && (!r_out_valid || i_m_tready);

    // ---- accumulation ----
    // pending area of a non-last rectangle is folded in on the following idle cycle
    assign acc_en   = ((r_state == S_IDLE) && r_pend) || ((r_state == S_LACC) && r_c_ne);
    assign sum_wide = {1'b0, r_area_sum} + (AREA_W + 1)'(prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_box <= 1'b0;
            r_box_l    <= '0;
            r_box_t    <= '0;
            r_box_r    <= '0;
            r_box_b    <= '0;
            r_area_sum <= '0;
            r_count    <= '0;
        end else if (out_load) begin
            r_have_box <= 1'b0;
            r_box_l    <= '0;
            r_box_t    <= '0;
            r_box_r    <= '0;
            r_box_b    <= '0;
            r_area_sum <= '0;
            r_count    <= '0;
        end else if (acc_en) begin
            if (r_count != COUNT_MAX) begin
                r_count <= r_count + CNT_W'(1);
            end
            r_area_sum <= sum_wide[AREA_W] ? AREA_MAX : sum_wide[AREA_W-1:0];
            r_have_box <= 1'b1;
            if (!r_have_box) begin
                r_box_l <= r_cl;
                r_box_t <= r_ct;
                r_box_r <= r_cr;
                r_box_b <= r_cb;
            end else begin
                if (r_cl < r_box_l) r_box_l <= r_cl;
                if (r_ct < r_box_t) r_box_t <= r_ct;
                if (r_cr > r_box_r) r_box_r <= r_cr;
                if (r_cb > r_box_b) r_box_b <= r_cb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SURF) begin
            r_mp <= prod;
        end
    end

    // ---- sequencer ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_xfer) n_state = S_AREA;
            S_AREA: n_state = r_c_last ? S_LACC : S_IDLE;
            S_LACC: n_state = S_MBOX;
            S_MBOX: n_state = S_SURF;
            S_SURF: n_state = S_DEC;
            S_DEC:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_c_ne   <= 1'b0;
            r_c_last <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                r_c_ne   <= c_ne;
                r_c_last <= i_s_tlast;
            end
            if (r_state == S_AREA && !r_c_last) begin
                r_pend <= r_c_ne;
            end else if (r_state == S_IDLE) begin
                r_pend <= 1'b0;
            end
        end
    end

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.pad            <= '0;
            r_out.merged_x       <= r_have_box ? OUT_DIM_W'(r_box_l) : '0;
            r_out.merged_y       <= r_have_box ? OUT_DIM_W'(r_box_t) : '0;
            r_out.merged_w       <= r_have_box ? OUT_DIM_W'(box_w) : '0;
            r_out.merged_h       <= r_have_box ? OUT_DIM_W'(box_h) : '0;
            r_out.damage_pixels  <= r_area_sum;
            r_out.rect_count     <= r_count;
            r_out.merged_pixels  <= MPIX_W'(mp_sel);
            r_out.full_upload    <= full;
            r_out.partial_upload <= !full;
            r_out.upload_bytes   <= BYTES_W'(KW'(up_sel) * KW'(BYTES_PER_PIX));
        end
    end

    assign o_m_tdata  = r_out;
    assign o_m_tvalid = r_out_valid;

endmodule

FILE: bench/tb_damage_rect_merge_upload_decide.sv
// Self-checking testbench for damage_rect_merge_upload_decide: clipping, box union,
// saturating totals and the full/partial upload decision, against an in-bench predictor.
// Depends on drmud_pkg and the RTL under hdl/.
module tb_damage_rect_merge_upload_decide;
    timeunit 1ns;
    timeprecision 1ps;

    import drmud_pkg::*;

    localparam int MAX_DIM = 8192;
    localparam longint AREA_SAT = (64'd1 << AREA_W) - 1;
    localparam int COUNT_SAT = 65535;

    typedef struct {
        t_coord x;
        t_coord y;
        t_coord w;
        t_coord h;
        logic   vld;
        logic   lst;
    } t_rect;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    logic                  i_s_tuser = 1'b0;
    logic                  i_s_tlast = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic                  i_cfg_index = REG_SURF_W;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    damage_rect_merge_upload_decide #(.MAX_DIM(MAX_DIM)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [CFG_W-1:0] surf_w_reg = 14'd1;
    logic [CFG_W-1:0] surf_h_reg = 14'd1;
    bit               have_box;
    longint           box_l, box_t, box_r, box_b;
    longint           area_sum;
    int               rect_tally;

    t_result upload_q[$];

    int src_gap_pct = 0;
    int sink_stall_pct = 0;
    int fail_count = 0;
    int rects_sent = 0;
    int uploads_checked = 0;

    function automatic longint clamp_dim(logic [CFG_W-1:0] r);
        if (r == 0) return 1;
        if (r > MAX_DIM) return MAX_DIM;
        return longint'(r);
    endfunction

    function automatic void clear_box();
        have_box = 0;
        box_l = 0;
        box_t = 0;
        box_r = 0;
        box_b = 0;
        area_sum = 0;
        rect_tally = 0;
    endfunction

    // accumulate one rectangle; on last, queue the expected upload decision
    task automatic predict_upload(t_rect it);
        longint sw, sh, surf, x, y, w, h, l, t, r, b, a, mw, mh, mp;
        logic   full;
        t_result res;
        sw = clamp_dim(surf_w_reg);
        sh = clamp_dim(surf_h_reg);
        surf = sw * sh;
        x = it.x;
        y = it.y;
        w = it.w;
        h = it.h;
        if (it.vld && w > 0 && h > 0) begin
            l = (x < 0) ? 0 : x;
            t = (y < 0) ? 0 : y;
            r = (x + w > sw) ? sw : x + w;
            b = (y + h > sh) ? sh : y + h;
            if (r > l && b > t) begin
                a = (r - l) * (b - t);
                if (rect_tally < COUNT_SAT) rect_tally++;
                area_sum = (a > AREA_SAT - area_sum) ? AREA_SAT : area_sum + a;
                if (!have_box) begin
                    box_l = l;
                    box_t = t;
                    box_r = r;
                    box_b = b;
                    have_box = 1;
                end else begin
                    if (l < box_l) box_l = l;
                    if (t < box_t) box_t = t;
                    if (r > box_r) box_r = r;
                    if (b > box_b) box_b = b;
                end
            end
        end
        if (!it.lst) return;
        res = '0;
        if (have_box) begin
            mw = box_r - box_l;
            mh = box_b - box_t;
            mp = mw * mh;
            full = (mp * PCT_ALL >= surf * PCT_FULL);
            res.merged_x = box_l[OUT_DIM_W-1:0];
            res.merged_y = box_t[OUT_DIM_W-1:0];
            res.merged_w = mw[OUT_DIM_W-1:0];
            res.merged_h = mh[OUT_DIM_W-1:0];
        end else begin
            mp = surf;
            full = 1'b1;
        end
        res.damage_pixels = area_sum[AREA_W-1:0];
        res.rect_count = rect_tally[CNT_W-1:0];
        res.merged_pixels = mp[MPIX_W-1:0];
        res.full_upload = full;
        res.partial_upload = ~full;
        a = (full ? surf : mp) * BYTES_PER_PIX;
        res.upload_bytes = a[BYTES_W-1:0];
        upload_q.push_back(res);
        clear_box();
    endtask

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            if (upload_q.size() == 0) begin
                $error("result transfer with no upload decision pending");
                fail_count++;
            end else begin
                want = upload_q.pop_front();
                check_field("merged_x", want.merged_x, got.merged_x);
                check_field("merged_y", want.merged_y, got.merged_y);
                check_field("merged_w", want.merged_w, got.merged_w);
                check_field("merged_h", want.merged_h, got.merged_h);
                check_field("damage_pixels", want.damage_pixels, got.damage_pixels);
                check_field("rect_count", want.rect_count, got.rect_count);
                check_field("merged_pixels", want.merged_pixels, got.merged_pixels);
                check_field("full_upload", want.full_upload, got.full_upload);
                check_field("partial_upload", want.partial_upload, got.partial_upload);
                check_field("upload_bytes", want.upload_bytes, got.upload_bytes);
                uploads_checked++;
            end
        end
    end

    task automatic send_rect(t_rect it);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < src_gap_pct) gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {it.h, it.w, it.y, it.x};
        i_s_tuser <= it.vld;
        i_s_tlast <= it.lst;
        do @(posedge i_clk); while (!o_s_tready);
        predict_upload(it);
        rects_sent++;
    endtask

    function automatic t_rect mk_rect(int x, int y, int w, int h, bit vld, bit lst);
        t_rect it;
        it.x = x[15:0];
        it.y = y[15:0];
        it.w = w[15:0];
        it.h = h[15:0];
        it.vld = vld;
        it.lst = lst;
        return it;
    endfunction

    // drop valid and hold off until every pending upload has come out
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (upload_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_SURF_W) surf_w_reg = val;
        else surf_h_reg = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_surface(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        wait_idle();
        write_reg(REG_SURF_W, w);
        write_reg(REG_SURF_H, h);
    endtask

    function automatic logic [CFG_W-1:0] pick_dim();
        int sel;
        sel = $urandom_range(99);
        if (sel < 8) return '0;
        if (sel < 16) return 14'(MAX_DIM + $urandom_range(1, 16383 - MAX_DIM));
        if (sel < 24) return 14'(MAX_DIM);
        if (sel < 32) return 14'd1;
        if (sel < 40) return 14'($urandom);
        return 14'($urandom_range(1, 64));
    endfunction

    function automatic t_rect random_rect(int sw, int sh);
        t_rect it;
        int    sel;
        sel = $urandom_range(99);
        if (sel < 12) begin
            // raw noise over the whole field range
            it.x = 16'($urandom);
            it.y = 16'($urandom);
            it.w = 16'($urandom);
            it.h = 16'($urandom);
        end else begin
            it.x = 16'($urandom_range(0, sw + 16) - 8);
            it.y = 16'($urandom_range(0, sh + 16) - 8);
            if (sel < 25) begin
                it.w = 16'($urandom_range(0, sw + 40));
                it.h = 16'($urandom_range(0, sh + 40));
            end else begin
                it.w = 16'($urandom_range(0, sw / 2 + 8) - 2);
                it.h = 16'($urandom_range(0, sh / 2 + 8) - 2);
            end
        end
        it.vld = ($urandom_range(99) >= 8);
        it.lst = 1'b0;
        return it;
    endfunction

    task automatic test_reset_surface();
        send_rect(mk_rect(0, 0, 1, 1, 1, 1));
        send_rect(mk_rect(0, 0, 0, 0, 0, 1));    // empty update
    endtask

    task automatic test_clip_extremes();
        set_surface(14'(MAX_DIM), 14'(MAX_DIM));
        send_rect(mk_rect(-32768, -32768, 32767, 32767, 1, 0));
        send_rect(mk_rect(32767, 32767, 32767, 32767, 1, 0));
        send_rect(mk_rect(0, 0, 32767, 32767, 1, 1));
        send_rect(mk_rect(-32768, -32768, -32768, -32768, 1, 1));
    endtask

    task automatic test_empty_dims();
        set_surface(14'd100, 14'd50);
        send_rect(mk_rect(5, 5, 0, 10, 1, 0));
        send_rect(mk_rect(5, 5, 10, 0, 1, 0));
        send_rect(mk_rect(5, 5, -1, 10, 1, 0));
        send_rect(mk_rect(5, 5, 10, 10, 0, 0));  // fields ignored without rect_valid
        send_rect(mk_rect(10, 20, 5, 3, 1, 1));
    endtask

    task automatic test_union();
        send_rect(mk_rect(-4, 2, 10, 3, 1, 0));
        send_rect(mk_rect(90, 40, 30, 30, 1, 0));
        send_rect(mk_rect(20, 10, 2, 2, 1, 0));
        send_rect(mk_rect(0, 0, 0, 0, 0, 1));
    endtask

    task automatic test_threshold();
        set_surface(14'd100, 14'd1);
        send_rect(mk_rect(0, 0, 60, 1, 1, 1));
        send_rect(mk_rect(0, 0, 59, 1, 1, 1));
        send_rect(mk_rect(41, 0, 100, 5, 1, 1));
    endtask

    task automatic test_clamp();
        set_surface(14'd0, 14'd16383);
        send_rect(mk_rect(0, 0, 5, 10000, 1, 1));
        set_surface(14'd12345, 14'd0);
        send_rect(mk_rect(8000, -3, 500, 9, 1, 1));
    endtask

    // surface resized between two rectangles of the same update
    task automatic test_resize_mid_update();
        set_surface(14'd100, 14'd100);
        send_rect(mk_rect(0, 0, 50, 50, 1, 0));
        set_surface(14'd20, 14'd100);
        send_rect(mk_rect(0, 0, 50, 50, 1, 1));
    endtask

    // many full-surface rectangles in one update carry the area sum well past 32 bits
    task automatic test_long_update();
        set_surface(14'(MAX_DIM), 14'(MAX_DIM));
        for (int i = 0; i < 200; i++) begin
            send_rect(mk_rect(0, 0, MAX_DIM, MAX_DIM, 1, i == 199));
        end
    endtask

    task automatic test_random_traffic(int n_items, int gap_pct, int stall_pct);
        int    sent;
        int    len;
        int    updates;
        t_rect it;
        src_gap_pct = gap_pct;
        sink_stall_pct = stall_pct;
        sent = 0;
        updates = 0;
        while (sent < n_items) begin
            if (updates % 10 == 0) set_surface(pick_dim(), pick_dim());
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                it = random_rect(int'(clamp_dim(surf_w_reg)), int'(clamp_dim(surf_h_reg)));
                it.lst = (i == len - 1);
                send_rect(it);
            end
            sent += len;
            updates++;
        end
    endtask

    initial begin
        clear_box();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_gap_pct = 8;
        sink_stall_pct = 71;
        test_reset_surface();
        test_clip_extremes();
        test_empty_dims();
        test_union();
        test_threshold();
        test_clamp();
        test_resize_mid_update();
        test_random_traffic(430, 8, 71);
        test_random_traffic(430, 71, 8);
        src_gap_pct = 0;
        sink_stall_pct = 0;
        test_long_update();
        test_random_traffic(430, 0, 0);

        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d rectangle transfers, checked %0d upload decisions", rects_sent,
                 uploads_checked);
        $display("(clipping, union, threshold, clamping, mid-update resize, long update).");
        if (fail_count == 0 && upload_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("FAILURE");
        $finish;
    end

endmodule
